// ----- rtl/egbr_pkg.sv -----
// Package with the widths, codes and helper functions of the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package egbr_pkg;

   localparam int DEPTH     = 4096;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CAP_W     = 13;
   localparam int OP_W      = 2;
   localparam int SIZE_W    = 7;
   localparam int COUNT_W   = 16;
   localparam int BYTE_W    = 8;
   localparam int DIV_STEPS = CAP_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_WR_REQ  = 2'd0;
   localparam op_type OP_WR_DATA = 2'd1;
   localparam op_type OP_RD_REQ  = 2'd2;
   localparam op_type OP_RD_DATA = 2'd3;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_NONE  = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_READ  = 2'd2;

   // Bytes held, given both pointers, the full flag and the capacity in use.
   function automatic logic [CAP_W-1:0] fill_calc(input logic [PTR_W-1:0] head,
                                                  input logic [PTR_W-1:0] tail,
                                                  input logic             full,
                                                  input logic [CAP_W-1:0] cap);
      if (full) begin
         return cap;
      end else if (head >= tail) begin
         return CAP_W'(head) - CAP_W'(tail);
      end else begin
         return cap - (CAP_W'(tail) - CAP_W'(head));
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/egbr_ifs.sv -----
// Request and response channel interfaces of the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

interface egbr_req_if;
   logic                          valid;
   logic                          ready;
   logic [egbr_pkg::OP_W-1:0]     operation;
   logic [egbr_pkg::SIZE_W-1:0]   elem_size;
   logic [egbr_pkg::COUNT_W-1:0]  elem_count;
   logic [egbr_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, operation, elem_size, elem_count, data_byte,
                   input ready);
   modport sink   (input valid, operation, elem_size, elem_count, data_byte,
                   output ready);
endinterface

interface egbr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [egbr_pkg::COUNT_W-1:0]  granted_count;
   logic [egbr_pkg::BYTE_W-1:0]   data_out;
   logic [egbr_pkg::CAP_W-1:0]    fill_bytes;
   logic                          out_of_window;

   modport source (output valid, granted_count, data_out, fill_bytes, out_of_window,
                   input ready);
   modport sink   (input valid, granted_count, data_out, fill_bytes, out_of_window,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/element_granular_byte_ring_fifo.sv -----
// Top level of the element-granular byte ring FIFO with its ring memory.
//
//   Channel   Direction  Handshake         Carries
//   req_port  in         valid / ready     operation, elem_size, elem_count, data_byte
//   rsp_port  out        valid / ready     granted_count, data_out, fill_bytes,
//                                          out_of_window
//   csr_*     in         write enable      capacity_bytes
//
// Data transactions stream one byte per cycle while the input does not stall.
// A request passes through acceptance, 13 steps of the bit-serial divider that splits
// the free room (write) or the fill (read) by the element size, and a grant state.
// Reset is synchronous and needs no clearing pass; the ring memory is not reset.
// The input stalls while a request is in the divider or grant state, during a capacity
// write, or while the response register holds a transaction the sink has not taken.
`timescale 1ns / 1ps
`default_nettype none

module element_granular_byte_ring_fifo (
   input  wire                          clock,
   input  wire                          reset,
   egbr_req_if.sink                     req_port,
   egbr_rsp_if.source                   rsp_port,
   input  wire                          csr_wr_en,
   input  wire [egbr_pkg::CAP_W-1:0]    csr_wr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [egbr_pkg::BYTE_W-1:0]   ring_mem [egbr_pkg::DEPTH];
   logic [egbr_pkg::BYTE_W-1:0]   mem_q_ff;
   logic                          mem_we;
   logic                          mem_re;

   logic [1:0]                    state_ff, state_in;
   logic [egbr_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [egbr_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [egbr_pkg::PTR_W-1:0]    tail_ff, tail_in;
   logic                          full_ff, full_in;
   logic [egbr_pkg::CAP_W-1:0]    win_left_ff, win_left_in;
   egbr_pkg::mode_type            win_mode_ff, win_mode_in;

   logic                          wr_req_ff, wr_req_in;
   logic [egbr_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [egbr_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [egbr_pkg::CAP_W-1:0]    quo_ff, quo_in;
   logic [egbr_pkg::SIZE_W-1:0]   rem_ff, rem_in;
   logic [egbr_pkg::STEP_W-1:0]   step_ff, step_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [egbr_pkg::COUNT_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [egbr_pkg::CAP_W-1:0]    rsp_fill_ff, rsp_fill_in;
   logic                          rsp_oow_ff, rsp_oow_in;
   logic                          rsp_rd_ff, rsp_rd_in;

   logic                          accept;
   logic                          rsp_free;
   logic [egbr_pkg::CAP_W-1:0]    cap_eff;
   logic [egbr_pkg::CAP_W-1:0]    fill_cur;
   logic [egbr_pkg::CAP_W-1:0]    head_inc;
   logic [egbr_pkg::CAP_W-1:0]    tail_inc;
   logic [egbr_pkg::SIZE_W:0]     trial;
   logic [egbr_pkg::SIZE_W:0]     trial_diff;
   logic                          trial_ge;
   logic [egbr_pkg::COUNT_W-1:0]  whole;
   logic [egbr_pkg::COUNT_W-1:0]  granted;
   logic [egbr_pkg::CAP_W+egbr_pkg::SIZE_W-1:0] win_prod;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = egbr_pkg::CAP_W'(1);
      end else if (cap_ff > egbr_pkg::CAP_MAX) begin
         cap_eff = egbr_pkg::CAP_MAX;
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign fill_cur   = egbr_pkg::fill_calc(head_ff, tail_ff, full_ff, cap_eff);
   assign head_inc   = egbr_pkg::CAP_W'(head_ff) + egbr_pkg::CAP_W'(1);
   assign tail_inc   = egbr_pkg::CAP_W'(tail_ff) + egbr_pkg::CAP_W'(1);
   assign trial      = {rem_ff, quo_ff[egbr_pkg::CAP_W-1]};
   assign trial_diff = trial - {1'b0, size_ff};
   assign trial_ge   = trial >= {1'b0, size_ff};
   assign whole      = egbr_pkg::COUNT_W'(quo_ff);
   assign win_prod   = (egbr_pkg::CAP_W+egbr_pkg::SIZE_W)'(granted[egbr_pkg::CAP_W-1:0])
                     * (egbr_pkg::CAP_W+egbr_pkg::SIZE_W)'(size_ff);

   always_comb begin
      if (size_ff == '0) begin
         granted = '0;
      end else if (count_ff < whole) begin
         granted = count_ff;
      end else begin
         granted = whole;
      end
   end

   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE) && rsp_free && !csr_wr_en;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      state_in       = state_ff;
      cap_in         = cap_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      full_in        = full_ff;
      win_left_in    = win_left_ff;
      win_mode_in    = win_mode_ff;
      wr_req_in      = wr_req_ff;
      size_in        = size_ff;
      count_in       = count_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_oow_in     = rsp_oow_ff;
      rsp_rd_in      = rsp_rd_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_port.operation) inside
                  egbr_pkg::OP_WR_REQ, egbr_pkg::OP_RD_REQ: begin
                     wr_req_in = req_port.operation == egbr_pkg::OP_WR_REQ;
                     size_in   = req_port.elem_size;
                     count_in  = req_port.elem_count;
                     quo_in    = wr_req_in ? cap_eff - fill_cur : fill_cur;
                     rem_in    = '0;
                     step_in   = '0;
                     state_in  = ST_DIV;
                  end
                  egbr_pkg::OP_WR_DATA: begin
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = '0;
                     rsp_rd_in      = 1'b0;
                     rsp_oow_in     = 1'b1;
                     if (win_mode_ff == egbr_pkg::MODE_WRITE && win_left_ff != '0
                         && !full_ff) begin
                        mem_we      = 1'b1;
                        rsp_oow_in  = 1'b0;
                        head_in     = (head_inc == cap_eff) ? '0
                                    : head_inc[egbr_pkg::PTR_W-1:0];
                        full_in     = head_in == tail_ff;
                        win_left_in = win_left_ff - egbr_pkg::CAP_W'(1);
                        if (win_left_in == '0) begin
                           win_mode_in = egbr_pkg::MODE_NONE;
                        end
                     end
                     rsp_fill_in = egbr_pkg::fill_calc(head_in, tail_in, full_in, cap_eff);
                  end
                  egbr_pkg::OP_RD_DATA: begin
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = '0;
                     rsp_rd_in      = 1'b0;
                     rsp_oow_in     = 1'b1;
                     if (win_mode_ff == egbr_pkg::MODE_READ && win_left_ff != '0
                         && fill_cur != '0) begin
                        mem_re      = 1'b1;
                        rsp_rd_in   = 1'b1;
                        rsp_oow_in  = 1'b0;
                        tail_in     = (tail_inc == cap_eff) ? '0
                                    : tail_inc[egbr_pkg::PTR_W-1:0];
                        full_in     = 1'b0;
                        win_left_in = win_left_ff - egbr_pkg::CAP_W'(1);
                        if (win_left_in == '0) begin
                           win_mode_in = egbr_pkg::MODE_NONE;
                        end
                     end
                     rsp_fill_in = egbr_pkg::fill_calc(head_in, tail_in, full_in, cap_eff);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[egbr_pkg::SIZE_W-1:0]
                               : trial[egbr_pkg::SIZE_W-1:0];
            quo_in  = {quo_ff[egbr_pkg::CAP_W-2:0], trial_ge};
            step_in = step_ff + egbr_pkg::STEP_W'(1);
            if (step_ff == egbr_pkg::STEP_W'(egbr_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               win_left_in    = win_prod[egbr_pkg::CAP_W-1:0];
               if (granted == '0) begin
                  win_mode_in = egbr_pkg::MODE_NONE;
               end else begin
                  win_mode_in = wr_req_ff ? egbr_pkg::MODE_WRITE : egbr_pkg::MODE_READ;
               end
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted;
               rsp_fill_in    = fill_cur;
               rsp_oow_in     = 1'b0;
               rsp_rd_in      = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity write empties the ring and closes any window.
      if (csr_wr_en) begin
         cap_in      = csr_wr_data;
         head_in     = '0;
         tail_in     = '0;
         full_in     = 1'b0;
         win_left_in = '0;
         win_mode_in = egbr_pkg::MODE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= egbr_pkg::CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b0;
         win_left_ff  <= '0;
         win_mode_ff  <= egbr_pkg::MODE_NONE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         win_left_ff  <= win_left_in;
         win_mode_ff  <= win_mode_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_req_ff      <= wr_req_in;
      size_ff        <= size_in;
      count_ff       <= count_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_oow_ff     <= rsp_oow_in;
      rsp_rd_ff      <= rsp_rd_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[head_ff] <= req_port.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_q_ff <= ring_mem[tail_ff];
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.granted_count = rsp_granted_ff;
   assign rsp_port.data_out      = rsp_rd_ff ? mem_q_ff : '0;
   assign rsp_port.fill_bytes    = rsp_fill_ff;
   assign rsp_port.out_of_window = rsp_oow_ff;

   a_window_consistent : assert property (@(posedge clock) disable iff (reset)
      (win_mode_ff == egbr_pkg::MODE_NONE) == (win_left_ff == '0))
      else $error("Window mode and byte count disagree.");

   a_pointers_in_ring : assert property (@(posedge clock) disable iff (reset)
      (egbr_pkg::CAP_W'(head_ff) < cap_eff) && (egbr_pkg::CAP_W'(tail_ff) < cap_eff))
      else $error("A ring pointer has passed the capacity in use.");

   a_full_pointers : assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (head_ff == tail_ff))
      else $error("Full flag set with differing pointers.");

   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_port.ready)
      else $error("Input ready while a request is being divided.");

   a_done_responds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free && !csr_wr_en) |=> rsp_valid_ff)
      else $error("Finished request produced no transaction.");

endmodule

`default_nettype wire
